// ===== src/chi2_pkg.sv =====
// Shared constants and state types for the chi-squared distance engine.
`default_nettype none
package chi2_pkg;

  localparam int LM_IDX_W   = 6;
  localparam int EL_IDX_W   = 8;
  localparam int VALUE_W    = 16;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 40;
  localparam int FRAC_BITS  = 16;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_IN_USE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDMARKS_IN_USE = 2'd1;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  typedef enum logic [1:0] {
    TP_IDLE,
    TP_SQUARE,
    TP_DIVIDE
  } term_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_WAIT,
    S_EMIT
  } run_state_t;

endpackage
`default_nettype wire

// ===== src/chi2_in_if.sv =====
// Input channel: landmark loads and query elements.
`default_nettype none
interface chi2_in_if import chi2_pkg::*;;
  logic                action;
  logic [LM_IDX_W-1:0] landmark_index;
  logic [EL_IDX_W-1:0] element_index;
  logic [VALUE_W-1:0]  value;
  logic                valid;
  logic                ready;

  modport source (output action, landmark_index, element_index, value, valid, input ready);
  modport sink   (input action, landmark_index, element_index, value, valid, output ready);
endinterface
`default_nettype wire

// ===== src/chi2_out_if.sv =====
// Output channel: one distance per landmark in use.
`default_nettype none
interface chi2_out_if import chi2_pkg::*;;
  logic [LM_IDX_W-1:0] result_landmark;
  logic [ACC_W-1:0]    distance;
  logic                last_of_run;
  logic                valid;
  logic                ready;

  modport source (output result_landmark, distance, last_of_run, valid, input ready);
  modport sink   (input result_landmark, distance, last_of_run, valid, output ready);
endinterface
`default_nettype wire

// ===== src/chi2_cross_distance_top.sv =====
// Top level of the chi-squared distance engine: sequencer, accumulator, ports.
//
// Usage: in_ch carries one element per transfer. action 0 loads a landmark
// bin at (landmark_index, element_index); action 1 buffers a query bin. The
// query bin at index dim_in_use-1 starts a run that yields one distance per
// landmark in use on out_ch, in landmark order, last_of_run on the final one.
// Loads and early query bins produce nothing.
// Each term takes a memory read, a square and a restoring division
// of 2*ELEMENT_BITS+16 steps; a term whose sum a+b is zero skips the
// division. A run takes dim_in_use * landmarks_in_use such terms plus
// one emit per landmark; the single term unit computes them one at a time.
// in_ch.ready is high only between runs. A finished distance waits in the
// output register; when the receiver stalls the sequencer holds in emit
// until the register frees, so nothing is lost or repeated.
// Reset (synchronous, active high) clears control and the accumulator and
// sets dim_in_use to 256 and landmarks_in_use to 64; memory contents are
// undefined until loaded. Configure only while idle via cfg_we/cfg_index.
`default_nettype none
module chi2_cross_distance_top import chi2_pkg::*; #(
  parameter int MAX_DIM       = 256,
  parameter int MAX_LANDMARKS = 64,
  parameter int ELEMENT_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  chi2_in_if.sink                   in_ch,
  chi2_out_if.source                out_ch
);

  localparam int DIM_AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LM_AW  = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int LS_AW  = (MAX_LANDMARKS*MAX_DIM > 1) ? $clog2(MAX_LANDMARKS*MAX_DIM) : 1;
  localparam int TW     = ELEMENT_BITS + FRAC_BITS;
  localparam int SW     = ((TW > ACC_W) ? TW : ACC_W) + 1;

  run_state_t state, state_next;

  logic [CFG_W-1:0]        dim_reg;
  logic [6:0]              nl_reg;
  logic [DIM_AW-1:0]       i_cnt;
  logic [LM_AW-1:0]        j_cnt;
  logic [ACC_W-1:0]        acc;

  logic [31:0]             dim_last32, nl_last32;
  logic [DIM_AW-1:0]       dim_last;
  logic [LM_AW-1:0]        nl_last;
  logic                    accept, trigger, out_free;
  logic                    in_ready, term_start;
  logic                    lm_we, q_we;
  logic [ELEMENT_BITS-1:0] wdata, lm_rdata, q_rdata;
  logic [LS_AW-1:0]        lm_waddr, lm_raddr;
  logic                    term_done;
  logic [TW-1:0]           term;
  logic [SW-1:0]           sum;
  logic [ACC_W-1:0]        acc_sat;

  // Clamp the registers to their usable ranges.
  always_comb begin
    if (dim_reg == '0) begin
      dim_last32 = 32'd0;
    end else if (32'(dim_reg) > 32'(MAX_DIM)) begin
      dim_last32 = 32'(MAX_DIM - 1);
    end else begin
      dim_last32 = 32'(dim_reg) - 32'd1;
    end
    if (nl_reg == '0) begin
      nl_last32 = 32'd0;
    end else if (32'(nl_reg) > 32'(MAX_LANDMARKS)) begin
      nl_last32 = 32'(MAX_LANDMARKS - 1);
    end else begin
      nl_last32 = 32'(nl_reg) - 32'd1;
    end
  end

  assign dim_last = dim_last32[DIM_AW-1:0];
  assign nl_last  = nl_last32[LM_AW-1:0];

  assign accept   = in_ch.valid && in_ready;
  assign trigger  = (in_ch.action == ACTION_QUERY) && (32'(in_ch.element_index) == dim_last32);
  assign out_free = !out_ch.valid || out_ch.ready;

  // Writes into the store; out-of-range indexes drop the element.
  assign wdata    = ELEMENT_BITS'(in_ch.value);
  assign lm_we    = accept && (in_ch.action == ACTION_LOAD)
                    && (32'(in_ch.landmark_index) < 32'(MAX_LANDMARKS))
                    && (32'(in_ch.element_index) < 32'(MAX_DIM));
  assign q_we     = accept && (in_ch.action == ACTION_QUERY)
                    && (32'(in_ch.element_index) < 32'(MAX_DIM));
  assign lm_waddr = LS_AW'(in_ch.landmark_index) * LS_AW'(MAX_DIM) + LS_AW'(in_ch.element_index);
  assign lm_raddr = LS_AW'(j_cnt) * LS_AW'(MAX_DIM) + LS_AW'(i_cnt);

  chi2_store #(
    .MAX_DIM       (MAX_DIM),
    .MAX_LANDMARKS (MAX_LANDMARKS),
    .ELEMENT_BITS  (ELEMENT_BITS),
    .DIM_AW        (DIM_AW),
    .LS_AW         (LS_AW)
  ) u_store (
    .clk      (clk),
    .lm_we    (lm_we),
    .lm_waddr (lm_waddr),
    .q_we     (q_we),
    .q_waddr  (DIM_AW'(in_ch.element_index)),
    .wdata    (wdata),
    .lm_raddr (lm_raddr),
    .q_raddr  (i_cnt),
    .lm_rdata (lm_rdata),
    .q_rdata  (q_rdata)
  );

  chi2_term #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_term (
    .clk   (clk),
    .rst   (rst),
    .start (term_start),
    .a     (q_rdata),
    .b     (lm_rdata),
    .done  (term_done),
    .term  (term)
  );

  // Saturating accumulate.
  assign sum     = SW'(acc) + SW'(term);
  assign acc_sat = (sum > SW'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && trigger) state_next = S_READ;
      S_READ:  state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT:  if (term_done) state_next = (i_cnt == dim_last) ? S_EMIT : S_READ;
      S_EMIT:  if (out_free) state_next = (j_cnt == nl_last) ? S_IDLE : S_READ;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    term_start = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_START: term_start = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      dim_reg       <= 9'd256;
      nl_reg        <= 7'd64;
      acc           <= '0;
      i_cnt         <= '0;
      j_cnt         <= '0;
      out_ch.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == CFG_DIM_IN_USE) begin
        dim_reg <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_LANDMARKS_IN_USE) begin
        nl_reg <= cfg_data[6:0];
      end
      // Present a new distance, or drop the old one once it has gone.
      if (state == S_EMIT && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && trigger) begin
            i_cnt <= '0;
            j_cnt <= '0;
            acc   <= '0;
          end
        end
        S_WAIT: begin
          if (term_done) begin
            acc <= acc_sat;
            if (i_cnt != dim_last) begin
              i_cnt <= i_cnt + 1'b1;
            end
          end
        end
        S_EMIT: begin
          // Hand the distance over and advance to the next landmark.
          if (out_free) begin
            j_cnt        <= j_cnt + 1'b1;
            i_cnt        <= '0;
            acc          <= '0;
          end
        end
        default: acc <= acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_ch.result_landmark <= LM_IDX_W'(j_cnt);
      out_ch.distance        <= acc;
      out_ch.last_of_run     <= (j_cnt == nl_last);
    end
  end

  a_term_in_wait : assert property (@(posedge clk) disable iff (rst)
    term_done |-> state == S_WAIT)
    else $error("term finished outside the wait state");

  a_last_matches : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last_of_run |-> out_ch.result_landmark == LM_IDX_W'(nl_last))
    else $error("last_of_run on a landmark other than the last in use");

  a_emit_loads : assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free |=> out_ch.valid)
    else $error("emitted distance not presented");

  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready)
    else $error("input taken during a run");

endmodule
`default_nettype wire

// ===== src/chi2_store.sv =====
// Landmark store and query buffer, synchronous memories with registered reads.
`default_nettype none
module chi2_store import chi2_pkg::*; #(
  parameter int MAX_DIM       = 256,
  parameter int MAX_LANDMARKS = 64,
  parameter int ELEMENT_BITS  = 16,
  parameter int DIM_AW        = 8,
  parameter int LS_AW         = 14
) (
  input  wire logic                    clk,
  input  wire logic                    lm_we,
  input  wire logic [LS_AW-1:0]        lm_waddr,
  input  wire logic                    q_we,
  input  wire logic [DIM_AW-1:0]       q_waddr,
  input  wire logic [ELEMENT_BITS-1:0] wdata,
  input  wire logic [LS_AW-1:0]        lm_raddr,
  input  wire logic [DIM_AW-1:0]       q_raddr,
  output      logic [ELEMENT_BITS-1:0] lm_rdata,
  output      logic [ELEMENT_BITS-1:0] q_rdata
);

  logic [ELEMENT_BITS-1:0] landmark_mem [MAX_LANDMARKS*MAX_DIM];
  logic [ELEMENT_BITS-1:0] query_mem [MAX_DIM];

  always_ff @(posedge clk) begin
    if (lm_we) begin
      landmark_mem[lm_waddr] <= wdata;
    end
    lm_rdata <= landmark_mem[lm_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      query_mem[q_waddr] <= wdata;
    end
    q_rdata <= query_mem[q_raddr];
  end

endmodule
`default_nettype wire

// ===== src/chi2_term.sv =====
// Term unit: (a-b)^2/(a+b) with 16 fractional bits, one quotient bit a cycle.
`default_nettype none
module chi2_term import chi2_pkg::*; #(
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [ELEMENT_BITS-1:0]           a,
  input  wire logic [ELEMENT_BITS-1:0]           b,
  output      logic                              done,
  output      logic [ELEMENT_BITS+FRAC_BITS-1:0] term
);

  localparam int EB    = ELEMENT_BITS;
  localparam int TW    = EB + FRAC_BITS;
  localparam int DW    = 2*EB + FRAC_BITS;
  localparam int CNT_W = $clog2(DW);

  term_phase_t phase, phase_next;

  logic [EB-1:0]    d_r;
  logic [EB:0]      s_r;
  logic [DW-1:0]    dividend;
  logic [EB:0]      rem;
  logic [TW-1:0]    quot;
  logic [CNT_W-1:0] cnt;

  logic             ld_ops, ld_sq, step, finish;
  logic [2*EB-1:0]  sq;
  logic [EB+1:0]    rem_sh, rem_sub;
  logic             ge;

  assign sq      = (2*EB)'(d_r) * (2*EB)'(d_r);
  assign rem_sh  = {rem, dividend[DW-1]};
  assign rem_sub = rem_sh - {1'b0, s_r};
  assign ge      = rem_sh >= {1'b0, s_r};

  always_comb begin
    phase_next = phase;
    case (phase)
      TP_IDLE:   if (start) phase_next = TP_SQUARE;
      TP_SQUARE: phase_next = (s_r == '0) ? TP_IDLE : TP_DIVIDE;
      TP_DIVIDE: if (cnt == CNT_W'(DW-1)) phase_next = TP_IDLE;
      default:   phase_next = TP_IDLE;
    endcase
  end

  always_comb begin
    ld_ops = 1'b0;
    ld_sq  = 1'b0;
    step   = 1'b0;
    finish = 1'b0;
    case (phase)
      TP_IDLE:   ld_ops = start;
      TP_SQUARE: begin
        ld_sq  = 1'b1;
        finish = (s_r == '0);
      end
      TP_DIVIDE: begin
        step   = 1'b1;
        finish = (cnt == CNT_W'(DW-1));
      end
      default:   ld_ops = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= TP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ops) begin
      d_r <= (a > b) ? (a - b) : (b - a);
      s_r <= (EB+1)'(a) + (EB+1)'(b);
    end
    if (ld_sq) begin
      dividend <= {sq, {FRAC_BITS{1'b0}}};
      rem      <= '0;
      quot     <= '0;
      cnt      <= '0;
    end
    if (step) begin
      dividend <= {dividend[DW-2:0], 1'b0};
      rem      <= ge ? rem_sub[EB:0] : rem_sh[EB:0];
      quot     <= {quot[TW-2:0], ge};
      cnt      <= cnt + 1'b1;
    end
  end

  assign term = quot;

endmodule
`default_nettype wire

// ===== sim/tb_chi2_cross_distance_top.sv =====
// Self-checking testbench for the chi-squared distance engine top level.
`default_nettype none
module tb_chi2_cross_distance_top;
  import chi2_pkg::*;

  // Register indexes past the end of the register list; the block ignores them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int N_LM       = 64;
  localparam int N_DIM      = 256;
  localparam int RAND_ITEMS = 400;
  localparam int DIR_DIM    = 32;
  localparam int SHAPE_MAX  = 96;
  localparam int PHASE_ONE  = 145;
  localparam int PHASE_TWO  = 290;
  // Longest quiet stretch: one landmark at 256 bins plus receiver stalls;
  // taken several times over.
  localparam int QUIET_LIMIT = 60000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic                action;
    logic [LM_IDX_W-1:0] lm;
    logic [EL_IDX_W-1:0] el;
    logic [VALUE_W-1:0]  value;
  } bin_item_t;

  typedef struct packed {
    logic [LM_IDX_W-1:0] lm;
    logic [ACC_W-1:0]    distance;
    logic                last;
  } distance_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  chi2_in_if  in_ch ();
  chi2_out_if out_ch ();

  chi2_cross_distance_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  // Stimulus waiting to be driven, and distances waiting to come out.
  bin_item_t bin_q[$];
  distance_t distance_q[$];

  // Shadow of the block used for prediction, updated on each accepted transfer.
  logic [VALUE_W-1:0] lm_mirror [N_LM*N_DIM];
  logic [VALUE_W-1:0] qry_mirror[N_DIM];
  logic [8:0] dim_reg = 9'd256;
  logic [6:0] nl_reg  = 7'd64;

  // Generator-side record of which entries have been written, so that no run
  // ever reads an entry that was never loaded.
  bit lm_loaded[N_LM][N_DIM];
  bit q_loaded[N_DIM];

  int  accepted = 0;
  int  rand_items = 0;
  int  runs = 0;
  int  checked = 0;
  int  errors = 0;
  int  quiet = 0;
  bit  in_took = 1'b0;

  function automatic int dim_eff();
    return (dim_reg < 1) ? 1 : (dim_reg > N_DIM) ? N_DIM : int'(dim_reg);
  endfunction

  function automatic int nl_eff();
    return (nl_reg < 1) ? 1 : (nl_reg > N_LM) ? N_LM : int'(nl_reg);
  endfunction

  // Exact fixed-point term (a-b)^2/(a+b), 16 fractional bits, truncated.
  function automatic logic [63:0] chi_term(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
    logic [63:0] s, d, d2, q, r;
    s = 64'(a) + 64'(b);
    if (s == 0) return 64'd0;
    d  = (a > b) ? 64'(a - b) : 64'(b - a);
    d2 = d * d;
    q  = d2 / s;
    r  = d2 % s;
    return (q << FRAC_BITS) + ((r << FRAC_BITS) / s);
  endfunction

  // Apply one accepted transfer; a query bin at the top index starts a run.
  task automatic apply_transfer(bin_item_t it);
    logic [63:0] acc, t;
    int dim, nl;
    distance_t d;
    if (it.action == ACTION_LOAD) begin
      lm_mirror[{it.lm, it.el}] = it.value;
    end else begin
      qry_mirror[it.el] = it.value;
      dim = dim_eff();
      nl  = nl_eff();
      if (int'(it.el) == dim - 1) begin
        runs++;
        for (int j = 0; j < nl; j++) begin
          acc = 0;
          for (int i = 0; i < dim; i++) begin
            t = chi_term(qry_mirror[i], lm_mirror[j*N_DIM + i]);
            if (t >= 64'(ACC_MAX) || acc > 64'(ACC_MAX) - t) acc = 64'(ACC_MAX);
            else acc = acc + t;
          end
          d.lm       = LM_IDX_W'(j);
          d.distance = acc[ACC_W-1:0];
          d.last     = (j == nl - 1);
          distance_q.push_back(d);
        end
      end
    end
  endtask

  // Idling schedule: sender light and receiver heavy, then swapped, then none.
  function automatic bit sender_idles();
    if (accepted < PHASE_ONE) return $urandom_range(0, 99) < 14;
    if (accepted < PHASE_TWO) return $urandom_range(0, 99) < 57;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (accepted < PHASE_ONE) return $urandom_range(0, 99) < 57;
    if (accepted < PHASE_TWO) return $urandom_range(0, 99) < 14;
    return 1'b0;
  endfunction

  // Input side: take transfers at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      apply_transfer(bin_q[0]);
      bin_q.pop_front();
      accepted++;
      in_took = 1'b1;
    end
  end

  // Driver: hold an offered item until it is taken, then advance or idle.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (bin_q.size() > 0 && !sender_idles()) begin
        in_ch.valid          <= 1'b1;
        in_ch.action         <= bin_q[0].action;
        in_ch.landmark_index <= bin_q[0].lm;
        in_ch.element_index  <= bin_q[0].el;
        in_ch.value          <= bin_q[0].value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_took = 1'b0;
    out_ch.ready <= rst ? 1'b0 : !receiver_stalls();
  end

  // Monitor: compare each distance transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (distance_q.size() == 0) begin
        $display("%0t: unexpected distance lm=%0d dist=%h last=%0b", $time,
                 out_ch.result_landmark, out_ch.distance, out_ch.last_of_run);
        errors++;
      end else begin
        if (out_ch.result_landmark !== distance_q[0].lm) begin
          $display("%0t: result_landmark expected %0d actual %0d", $time,
                   distance_q[0].lm, out_ch.result_landmark);
          errors++;
        end
        if (out_ch.distance !== distance_q[0].distance) begin
          $display("%0t: distance (lm %0d) expected %h actual %h", $time,
                   distance_q[0].lm, distance_q[0].distance, out_ch.distance);
          errors++;
        end
        if (out_ch.last_of_run !== distance_q[0].last) begin
          $display("%0t: last_of_run (lm %0d) expected %0b actual %0b", $time,
                   distance_q[0].lm, distance_q[0].last, out_ch.last_of_run);
          errors++;
        end
        distance_q.pop_front();
        checked++;
      end
    end
  end

  // Watchdog: drop the run if nothing transfers for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired, %0d distances outstanding", $time,
               distance_q.size());
      $display("tb_chi2_cross_distance_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DIM_IN_USE) dim_reg = data;
    else if (idx == CFG_LANDMARKS_IN_USE) nl_reg = data[6:0];
  endtask

  task automatic push_bin(logic act, int lm, int el, logic [VALUE_W-1:0] v);
    bin_item_t it;
    it.action = act;
    it.lm     = LM_IDX_W'(lm);
    it.el     = EL_IDX_W'(el);
    it.value  = v;
    if (act == ACTION_LOAD) lm_loaded[lm][el] = 1'b1;
    else q_loaded[el] = 1'b1;
    bin_q.push_back(it);
    rand_items++;
  endtask

  // Wait for the block to go idle before touching the registers.
  task automatic settle();
    while (bin_q.size() > 0 || distance_q.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'($urandom_range(0, 15));
      default: return VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // One well-formed run: some noise, fill or refresh every landmark bin in
  // use, refresh the query bins, then the trigger bin.
  task automatic gen_run(int dim, int nl);
    int el;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 1)) begin
        push_bin(ACTION_LOAD, $urandom_range(0, 63), $urandom_range(0, 255), pick_value());
      end else begin
        el = $urandom_range(0, 255);
        if (el == dim - 1) el = (el + 1) % N_DIM;
        push_bin(ACTION_QUERY, $urandom_range(0, 63), el, pick_value());
      end
    end
    for (int j = 0; j < nl; j++)
      for (int i = 0; i < dim; i++)
        if (!lm_loaded[j][i] || $urandom_range(0, 3) == 0)
          push_bin(ACTION_LOAD, j, i, pick_value());
    for (int i = 0; i < dim - 1; i++)
      if (!q_loaded[i] || $urandom_range(0, 2) > 0)
        push_bin(ACTION_QUERY, $urandom_range(0, 63), i, pick_value());
    push_bin(ACTION_QUERY, $urandom_range(0, 63), dim - 1, pick_value());
  endtask

  initial begin
    int dim, nl;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACTION_LOAD;
    in_ch.landmark_index = '0;
    in_ch.element_index  = '0;
    in_ch.value          = '0;
    out_ch.ready         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: one bin per vector (zero clamps up) and every landmark
    // (over-range clamps down); extreme query values against mixed landmarks.
    settle();
    write_reg(CFG_DIM_IN_USE, 9'd0);
    write_reg(CFG_LANDMARKS_IN_USE, 9'd127);
    for (int j = 0; j < N_LM; j++)
      push_bin(ACTION_LOAD, j, 0, (j % 3 == 0) ? 16'h0000 :
                                  (j % 3 == 1) ? 16'hFFFF : pick_value());
    push_bin(ACTION_QUERY, 63, 0, 16'hFFFF);
    push_bin(ACTION_QUERY, 0, 0, 16'h0000);
    push_bin(ACTION_QUERY, 21, 0, pick_value());

    // Directed: a single landmark (zero clamps up); all-max query against an
    // all-zero landmark gives the largest terms, and the zero top bin gives a
    // term with a zero denominator.
    settle();
    write_reg(CFG_DIM_IN_USE, CFG_W'(DIR_DIM));
    write_reg(CFG_LANDMARKS_IN_USE, 9'd0);
    write_reg(CFG_SPARE_A, 9'h1FF);
    write_reg(CFG_SPARE_B, 9'h000);
    for (int i = 0; i < DIR_DIM; i++) push_bin(ACTION_LOAD, 0, i, 16'h0000);
    for (int i = 0; i < DIR_DIM - 1; i++) push_bin(ACTION_QUERY, 0, i, 16'hFFFF);
    push_bin(ACTION_QUERY, 0, DIR_DIM - 1, 16'h0000);
    push_bin(ACTION_QUERY, 0, DIR_DIM - 1, pick_value());

    // Random: mostly small shapes, a few wider ones, one to four runs per setting.
    while (rand_items < RAND_ITEMS) begin
      settle();
      dim = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      nl  = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 64 / dim + 9) :
                                          $urandom_range(1, 8);
      if (nl > N_LM) nl = N_LM;
      if (dim * nl > SHAPE_MAX) nl = SHAPE_MAX / dim;
      write_reg(CFG_DIM_IN_USE, CFG_W'(dim));
      write_reg(CFG_LANDMARKS_IN_USE, CFG_W'(nl));
      repeat ($urandom_range(1, 4))
        if (rand_items < RAND_ITEMS) gen_run(dim, nl);
    end

    settle();
    $display("Covered %0d bin transfers and %0d runs; %0d distances checked.",
             accepted, runs, checked);
    if (errors == 0) begin
      $display("tb_chi2_cross_distance_top: PASS");
    end else begin
      $display("tb_chi2_cross_distance_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/chi2_pkg.sv
src/chi2_in_if.sv
src/chi2_out_if.sv
src/chi2_store.sv
src/chi2_term.sv
src/chi2_cross_distance_top.sv
sim/tb_chi2_cross_distance_top.sv
